FILE: src/cnm_pkg.sv
// package for the can network management mode machine
// holds event codes, mode and substate encodings, state and result structs
// no dependencies
package cnm_pkg;

  typedef enum logic [2:0] {
    CMD_MAIN    = 3'd0,
    CMD_RX      = 3'd1,
    CMD_REQUEST = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_TIMEOUT = 3'd4,
    CMD_SLEEP   = 3'd5,
    CMD_INIT    = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_SLEEP = 3'b001,
    MODE_NET   = 3'b010,
    MODE_PREP  = 3'b100
  } mode_e;

  typedef enum logic [3:0] {
    SUB_NONE   = 4'b0001,
    SUB_REPEAT = 4'b0010,
    SUB_READY  = 4'b0100,
    SUB_NORMAL = 4'b1000
  } sub_e;

  typedef enum logic [1:0] {
    WK_SLEEP   = 2'd0,
    WK_PASSIVE = 2'd1,
    WK_ACTIVE  = 2'd2
  } wake_e;

  typedef enum logic [1:0] {
    TS_STOPPED = 2'd0,
    TS_RUNNING = 2'd1,
    TS_TIMEOUT = 2'd2
  } tstat_e;

  localparam int unsigned NUM_TIMERS = 4;

  localparam logic [1:0] TM_REP = 2'd0;
  localparam logic [1:0] TM_NM  = 2'd1;
  localparam logic [1:0] TM_BUS = 2'd2;
  localparam logic [1:0] TM_CYC = 2'd3;

  localparam logic [1:0] MODE_CODE_SLEEP = 2'd0;
  localparam logic [1:0] MODE_CODE_NET   = 2'd1;
  localparam logic [1:0] MODE_CODE_PREP  = 2'd2;

  localparam logic [1:0] SUB_CODE_NONE   = 2'd0;
  localparam logic [1:0] SUB_CODE_REPEAT = 2'd1;
  localparam logic [1:0] SUB_CODE_READY  = 2'd2;
  localparam logic [1:0] SUB_CODE_NORMAL = 2'd3;

  localparam logic [7:0] PDU_FIRST_BYTE_RST = 8'd11;

  typedef struct packed {
    mode_e                     mode;
    sub_e                      sub;
    wake_e                     wake;
    tstat_e [NUM_TIMERS-1:0]   tstat;
    logic                      net_req;
    logic                      rx_flag;
    logic                      tx_flag;
    logic                      rbit_seen;
    logic                      rep_req;
    logic                      send_rep;
  } nm_state_t;

  typedef struct packed {
    logic                  send_nm_pdu;
    logic [NUM_TIMERS-1:0] restart_mask;
    logic [NUM_TIMERS-1:0] start_mask;
    logic [NUM_TIMERS-1:0] stop_mask;
    logic [1:0]            nm_mode;
    logic [1:0]            substate;
    logic                  net_req;
  } nm_result_t;

  localparam nm_state_t NM_STATE_RST = '{
    mode:      MODE_SLEEP,
    sub:       SUB_NONE,
    wake:      WK_SLEEP,
    tstat:     {NUM_TIMERS{TS_STOPPED}},
    net_req:   1'b0,
    rx_flag:   1'b0,
    tx_flag:   1'b0,
    rbit_seen: 1'b0,
    rep_req:   1'b0,
    send_rep:  1'b0
  };

  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] c;
    c = MODE_CODE_SLEEP;
    unique case (m)
      MODE_SLEEP: c = MODE_CODE_SLEEP;
      MODE_NET:   c = MODE_CODE_NET;
      MODE_PREP:  c = MODE_CODE_PREP;
      default:    c = MODE_CODE_SLEEP;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] sub_code(sub_e s);
    logic [1:0] c;
    c = SUB_CODE_NONE;
    unique case (s)
      SUB_NONE:   c = SUB_CODE_NONE;
      SUB_REPEAT: c = SUB_CODE_REPEAT;
      SUB_READY:  c = SUB_CODE_READY;
      SUB_NORMAL: c = SUB_CODE_NORMAL;
      default:    c = SUB_CODE_NONE;
    endcase
    return c;
  endfunction

endpackage

FILE: src/cnm_event.sv
// event decode and next-state logic of the network management mode machine
// combinational: current state plus one event gives next state and one result
// depends on cnm_pkg
module cnm_event import cnm_pkg::*; (
  input  nm_state_t  st_i,
  input  logic [2:0] cmd_i,
  input  logic       rx_repeat_bit_i,
  input  logic [1:0] timer_id_i,
  output nm_state_t  st_o,
  output nm_result_t res_o
);

  nm_state_t             s;
  logic                  send;
  logic [NUM_TIMERS-1:0] m_restart;
  logic [NUM_TIMERS-1:0] m_start;
  logic [NUM_TIMERS-1:0] m_stop;

  always_comb begin
    s         = st_i;
    send      = 1'b0;
    m_restart = '0;
    m_start   = '0;
    m_stop    = '0;

    unique case (cmd_e'(cmd_i))
      CMD_MAIN: begin
        unique case (st_i.mode)
          MODE_SLEEP: begin
            if (s.wake != WK_SLEEP) begin
              s.tstat[TM_NM]  = TS_RUNNING;
              s.tstat[TM_REP] = TS_RUNNING;
              m_start[TM_NM]  = 1'b1;
              m_start[TM_REP] = 1'b1;
              s.mode          = MODE_NET;
              s.sub           = SUB_REPEAT;
              s.send_rep      = 1'b1;
            end
          end
          MODE_NET: begin
            unique case (st_i.sub)
              SUB_REPEAT: begin
                if (s.send_rep) begin
                  s.send_rep = 1'b0;
                  send       = 1'b1;
                end
                if (s.tstat[TM_NM] == TS_TIMEOUT || s.rx_flag || s.tx_flag) begin
                  m_restart[TM_NM] = 1'b1;
                  s.rx_flag        = 1'b0;
                end
                if (s.tstat[TM_REP] == TS_TIMEOUT && s.tstat[TM_NM] == TS_RUNNING) begin
                  m_restart[TM_NM] = 1'b1;
                  if (!s.net_req) begin
                    s.sub           = SUB_READY;
                    m_start[TM_BUS] = 1'b1;
                  end else begin
                    m_start[TM_CYC] = 1'b1;
                    s.sub           = SUB_NORMAL;
                  end
                end
              end
              SUB_READY: begin
                if (s.rx_flag) begin
                  s.rx_flag        = 1'b0;
                  m_restart[TM_NM] = 1'b1;
                  if (s.rbit_seen) begin
                    s.rep_req = 1'b1;
                  end
                end else if (s.tx_flag) begin
                  m_restart[TM_NM] = 1'b1;
                  s.sub            = SUB_NORMAL;
                end
                if (s.tstat[TM_NM] == TS_TIMEOUT) begin
                  s.sub             = SUB_NONE;
                  s.mode            = MODE_PREP;
                  s.tstat[TM_BUS]   = TS_RUNNING;
                  s.tstat[TM_NM]    = TS_STOPPED;
                  m_restart[TM_BUS] = 1'b1;
                end
                if (s.rep_req) begin
                  s.rep_req         = 1'b0;
                  s.sub             = SUB_REPEAT;
                  s.send_rep        = 1'b1;
                  s.tstat[TM_REP]   = TS_RUNNING;
                  m_restart[TM_REP] = 1'b1;
                end
              end
              SUB_NORMAL: begin
                send = 1'b1;
                if (s.rx_flag || s.tx_flag) begin
                  m_restart[TM_NM] = 1'b1;
                  s.rx_flag        = 1'b0;
                  if (s.rbit_seen) begin
                    s.rep_req = 1'b1;
                  end
                end
                if (s.rep_req) begin
                  s.rep_req         = 1'b0;
                  s.sub             = SUB_REPEAT;
                  s.send_rep        = 1'b1;
                  s.tstat[TM_REP]   = TS_RUNNING;
                  m_restart[TM_REP] = 1'b1;
                end else if (!s.net_req) begin
                  s.sub = SUB_READY;
                end else if (s.tx_flag) begin
                  s.tx_flag = 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
          MODE_PREP: begin
            if (s.tstat[TM_BUS] == TS_TIMEOUT) begin
              s.mode      = MODE_SLEEP;
              s.wake      = WK_SLEEP;
              s.sub       = SUB_NONE;
              s.tstat     = {NUM_TIMERS{TS_STOPPED}};
              m_stop      = '1;
              s.net_req   = 1'b0;
              s.rx_flag   = 1'b0;
              s.tx_flag   = 1'b0;
              s.rbit_seen = 1'b0;
              s.rep_req   = 1'b0;
            end
            if (s.rx_flag || s.tx_flag) begin
              s.mode          = MODE_NET;
              s.tstat[TM_NM]  = TS_RUNNING;
              s.tstat[TM_REP] = TS_RUNNING;
              s.sub           = SUB_REPEAT;
              s.send_rep      = 1'b1;
              m_start[TM_REP] = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      CMD_RX: begin
        s.rx_flag   = 1'b1;
        s.rbit_seen = rx_repeat_bit_i;
        if (st_i.mode == MODE_SLEEP) begin
          s.wake = WK_PASSIVE;
        end
      end
      CMD_REQUEST: begin
        s.net_req       = 1'b1;
        s.tx_flag       = 1'b1;
        s.tstat[TM_CYC] = TS_RUNNING;
        if (st_i.mode == MODE_SLEEP) begin
          s.wake = WK_ACTIVE;
        end
      end
      CMD_RELEASE: begin
        s.net_req       = 1'b0;
        s.tstat[TM_CYC] = TS_STOPPED;
        s.tx_flag       = 1'b0;
        m_stop[TM_CYC]  = 1'b1;
      end
      CMD_TIMEOUT: begin
        s.tstat[timer_id_i] = TS_TIMEOUT;
      end
      CMD_SLEEP, CMD_INIT: begin
        s.mode      = MODE_SLEEP;
        s.wake      = WK_SLEEP;
        s.sub       = SUB_NONE;
        s.tstat     = {NUM_TIMERS{TS_STOPPED}};
        m_stop      = '1;
        s.net_req   = 1'b0;
        s.rx_flag   = 1'b0;
        s.tx_flag   = 1'b0;
        s.rbit_seen = 1'b0;
        s.rep_req   = 1'b0;
        if (cmd_e'(cmd_i) == CMD_INIT) begin
          m_start = '1;
        end
      end
      default: begin
      end
    endcase
  end

  assign st_o = s;

  assign res_o.send_nm_pdu  = send;
  assign res_o.restart_mask = m_restart;
  assign res_o.start_mask   = m_start;
  assign res_o.stop_mask    = m_stop;
  assign res_o.nm_mode      = mode_code(s.mode);
  assign res_o.substate     = sub_code(s.sub);
  assign res_o.net_req      = s.net_req;

endmodule

FILE: src/cnm_out_reg.sv
// result register of the network management mode machine
// holds one result until taken; loads a new one in the cycle the old one leaves
// depends on cnm_pkg
module cnm_out_reg import cnm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  nm_result_t res_i,
  output logic       space_o,
  output logic       valid_o,
  input  logic       ready_i,
  output nm_result_t res_o
);

  logic       valid_q;
  logic       valid_d;
  nm_result_t res_q;

  assign space_o = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: src/can_network_management_fsm_core.sv
// top level of the can network management mode machine
// holds mode, substate, timer and flag state; uses cnm_event, cnm_out_reg, cnm_pkg
//
// channel  direction  handshake                 payload
// in       to core    in_valid_i / in_ready_o   cmd_i, rx_repeat_bit_i, timer_id_i
// out      from core  out_valid_o / out_ready_i send_nm_pdu_o, timer_*_mask_o, nm_mode_o,
//                                               network_substate_o, net_request_o
// cfg      to core    cfg_valid_i / cfg_ready_o cfg_pdu_first_byte_i
//
// one transaction in gives one transaction out, held in the result register until taken
// an input is taken every cycle while the result register is empty or being drained
// the state update and result are computed combinationally from the state registers
// reset returns to bus sleep with all timers stopped; no clearing pass
// a stalled output holds the result and blocks new input until it is taken
module can_network_management_fsm_core import cnm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] cmd_i,
  input  logic       rx_repeat_bit_i,
  input  logic [1:0] timer_id_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       send_nm_pdu_o,
  output logic [3:0] timer_restart_mask_o,
  output logic [3:0] timer_start_mask_o,
  output logic [3:0] timer_stop_mask_o,
  output logic [1:0] nm_mode_o,
  output logic [1:0] network_substate_o,
  output logic       net_request_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_pdu_first_byte_i
);

  nm_state_t  state_q;
  nm_state_t  state_d;
  nm_result_t res_d;
  nm_result_t res_q;
  logic       accept;
  logic       space;
  logic [7:0] pdu_first_byte_q;

  assign in_ready_o  = space;
  assign accept      = in_valid_i && space;
  assign cfg_ready_o = 1'b1;

  cnm_event u_event (
    .st_i            (state_q),
    .cmd_i           (cmd_i),
    .rx_repeat_bit_i (rx_repeat_bit_i),
    .timer_id_i      (timer_id_i),
    .st_o            (state_d),
    .res_o           (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NM_STATE_RST;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pdu_first_byte_q <= PDU_FIRST_BYTE_RST;
    end else if (cfg_valid_i) begin
      pdu_first_byte_q <= cfg_pdu_first_byte_i;
    end
  end

  cnm_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .res_i   (res_d),
    .space_o (space),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res_q)
  );

  assign send_nm_pdu_o        = res_q.send_nm_pdu;
  assign timer_restart_mask_o = res_q.restart_mask;
  assign timer_start_mask_o   = res_q.start_mask;
  assign timer_stop_mask_o    = res_q.stop_mask;
  assign nm_mode_o            = res_q.nm_mode;
  assign network_substate_o   = res_q.substate;
  assign net_request_o        = res_q.net_req;

endmodule

FILE: src/cnm_checker.sv
// port-level checks of the can network management mode machine
// bound to can_network_management_fsm_core; depends on cnm_pkg
module cnm_checker import cnm_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [2:0] cmd_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       send_nm_pdu_o,
  input logic [3:0] timer_stop_mask_o,
  input logic [1:0] nm_mode_o,
  input logic [1:0] network_substate_o
);

  // stalled result transaction holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(nm_mode_o)
      && $stable(network_substate_o) && $stable(timer_stop_mask_o))
    else $error("stalled result changed");

  // sleep and init stop every timer and land in bus sleep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == CMD_SLEEP || cmd_i == CMD_INIT)
      |=> out_valid_o && timer_stop_mask_o == 4'hF && nm_mode_o == MODE_CODE_SLEEP)
    else $error("sleep transaction did not stop timers");

  // bus sleep carries no substate and sends nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && nm_mode_o == MODE_CODE_SLEEP
      |-> network_substate_o == SUB_CODE_NONE && !send_nm_pdu_o)
    else $error("bus sleep with substate or transmit");

  // network mode always has a substate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && nm_mode_o == MODE_CODE_NET |-> network_substate_o != SUB_CODE_NONE)
    else $error("network mode without substate");

endmodule

bind can_network_management_fsm_core cnm_checker u_cnm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .cmd_i              (cmd_i),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .send_nm_pdu_o      (send_nm_pdu_o),
  .timer_stop_mask_o  (timer_stop_mask_o),
  .nm_mode_o          (nm_mode_o),
  .network_substate_o (network_substate_o)
);

FILE: tb/can_network_management_fsm_core_tb.sv
`timescale 1ns / 1ps
// testbench for can_network_management_fsm_core: random and directed nm events, checked
// against an in-bench model of the mode machine; depends on cnm_pkg and the core rtl
module can_network_management_fsm_core_tb import cnm_pkg::*; ();

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int unsigned EVENTS_PER_PHASE = 225;

  typedef struct packed {
    logic [2:0] cmd;
    logic       rx_bit;
    logic [1:0] tid;
  } nm_event_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [2:0] cmd_i = 3'd0;
  logic       rx_repeat_bit_i = 1'b0;
  logic [1:0] timer_id_i = 2'd0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       send_nm_pdu_o;
  logic [3:0] timer_restart_mask_o;
  logic [3:0] timer_start_mask_o;
  logic [3:0] timer_stop_mask_o;
  logic [1:0] nm_mode_o;
  logic [1:0] network_substate_o;
  logic       net_request_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_pdu_first_byte_i = 8'd0;

  can_network_management_fsm_core u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .cmd_i                (cmd_i),
    .rx_repeat_bit_i      (rx_repeat_bit_i),
    .timer_id_i           (timer_id_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .send_nm_pdu_o        (send_nm_pdu_o),
    .timer_restart_mask_o (timer_restart_mask_o),
    .timer_start_mask_o   (timer_start_mask_o),
    .timer_stop_mask_o    (timer_stop_mask_o),
    .nm_mode_o            (nm_mode_o),
    .network_substate_o   (network_substate_o),
    .net_request_o        (net_request_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_pdu_first_byte_i (cfg_pdu_first_byte_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  logic [1:0] mode_q;
  logic [1:0] sub_q;
  wake_e      wake_q;
  tstat_e     tm_state [NUM_TIMERS];
  logic       net_req_q;
  logic       rx_q;
  logic       tx_q;
  logic       rbit_q;
  logic       rep_req_q;
  logic       send_rep_q;
  logic [7:0] pdu_byte_q;

  nm_event_t   event_q[$];
  nm_result_t  nm_status_q[$];
  nm_event_t   cur_ev = '0;
  int unsigned events_queued = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic [15:0] stall_tick = '0;

  function automatic void go_bus_sleep(inout nm_result_t r);
    mode_q = MODE_CODE_SLEEP;
    wake_q = WK_SLEEP;
    sub_q = SUB_CODE_NONE;
    foreach (tm_state[i]) tm_state[i] = TS_STOPPED;
    r.stop_mask = 4'hF;
    net_req_q = 1'b0;
    rx_q = 1'b0;
    tx_q = 1'b0;
    rbit_q = 1'b0;
    rep_req_q = 1'b0;
  endfunction

  function automatic void enter_repeat(inout nm_result_t r);
    rep_req_q = 1'b0;
    sub_q = SUB_CODE_REPEAT;
    send_rep_q = 1'b1;
    tm_state[TM_REP] = TS_RUNNING;
    r.restart_mask[TM_REP] = 1'b1;
  endfunction

  function automatic nm_result_t apply_nm_event(nm_event_t ev);
    nm_result_t r;
    r = '0;
    case (ev.cmd)
      CMD_MAIN: begin
        if (mode_q == MODE_CODE_SLEEP) begin
          if (wake_q != WK_SLEEP) begin
            tm_state[TM_NM] = TS_RUNNING;
            tm_state[TM_REP] = TS_RUNNING;
            r.start_mask[TM_NM] = 1'b1;
            r.start_mask[TM_REP] = 1'b1;
            mode_q = MODE_CODE_NET;
            sub_q = SUB_CODE_REPEAT;
            send_rep_q = 1'b1;
          end
        end else if (mode_q == MODE_CODE_NET) begin
          case (sub_q)
            SUB_CODE_REPEAT: begin
              if (send_rep_q) begin
                send_rep_q = 1'b0;
                r.send_nm_pdu = 1'b1;
              end
              if (tm_state[TM_NM] == TS_TIMEOUT || rx_q || tx_q) begin
                r.restart_mask[TM_NM] = 1'b1;
                rx_q = 1'b0;
              end
              if (tm_state[TM_REP] == TS_TIMEOUT && tm_state[TM_NM] == TS_RUNNING) begin
                r.restart_mask[TM_NM] = 1'b1;
                if (!net_req_q) begin
                  sub_q = SUB_CODE_READY;
                  r.start_mask[TM_BUS] = 1'b1;
                end else begin
                  r.start_mask[TM_CYC] = 1'b1;
                  sub_q = SUB_CODE_NORMAL;
                end
              end
            end
            SUB_CODE_READY: begin
              if (rx_q) begin
                rx_q = 1'b0;
                r.restart_mask[TM_NM] = 1'b1;
                if (rbit_q) rep_req_q = 1'b1;
              end else if (tx_q) begin
                r.restart_mask[TM_NM] = 1'b1;
                sub_q = SUB_CODE_NORMAL;
              end
              if (tm_state[TM_NM] == TS_TIMEOUT) begin
                sub_q = SUB_CODE_NONE;
                mode_q = MODE_CODE_PREP;
                tm_state[TM_BUS] = TS_RUNNING;
                tm_state[TM_NM] = TS_STOPPED;
                r.restart_mask[TM_BUS] = 1'b1;
              end
              if (rep_req_q) enter_repeat(r);
            end
            SUB_CODE_NORMAL: begin
              r.send_nm_pdu = 1'b1;
              if (rx_q || tx_q) begin
                r.restart_mask[TM_NM] = 1'b1;
                rx_q = 1'b0;
                if (rbit_q) rep_req_q = 1'b1;
              end
              if (rep_req_q) enter_repeat(r);
              else if (!net_req_q) sub_q = SUB_CODE_READY;
              else if (tx_q) tx_q = 1'b0;
            end
            default: ;
          endcase
        end else if (mode_q == MODE_CODE_PREP) begin
          if (tm_state[TM_BUS] == TS_TIMEOUT) begin
            tm_state[TM_BUS] = TS_STOPPED;
            go_bus_sleep(r);
          end
          if (rx_q || tx_q) begin
            mode_q = MODE_CODE_NET;
            tm_state[TM_NM] = TS_RUNNING;
            tm_state[TM_REP] = TS_RUNNING;
            sub_q = SUB_CODE_REPEAT;
            send_rep_q = 1'b1;
            r.start_mask[TM_REP] = 1'b1;
          end
        end
      end
      CMD_RX: begin
        rx_q = 1'b1;
        rbit_q = ev.rx_bit;
        if (mode_q == MODE_CODE_SLEEP) wake_q = WK_PASSIVE;
      end
      CMD_REQUEST: begin
        net_req_q = 1'b1;
        tx_q = 1'b1;
        tm_state[TM_CYC] = TS_RUNNING;
        if (mode_q == MODE_CODE_SLEEP) wake_q = WK_ACTIVE;
      end
      CMD_RELEASE: begin
        net_req_q = 1'b0;
        tm_state[TM_CYC] = TS_STOPPED;
        tx_q = 1'b0;
        r.stop_mask[TM_CYC] = 1'b1;
      end
      CMD_TIMEOUT: tm_state[ev.tid] = TS_TIMEOUT;
      CMD_SLEEP:   go_bus_sleep(r);
      CMD_INIT: begin
        go_bus_sleep(r);
        r.start_mask = 4'hF;
      end
      default: ;
    endcase
    r.nm_mode = mode_q;
    r.substate = sub_q;
    r.net_req = net_req_q;
    return r;
  endfunction

  function automatic void queue_event(logic [2:0] c, logic b, logic [1:0] t);
    nm_event_t ev;
    ev.cmd = c;
    ev.rx_bit = b;
    ev.tid = t;
    event_q.push_back(ev);
    events_queued++;
  endfunction

  function automatic void queue_any(logic [2:0] c);
    queue_event(c, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
  endfunction

  function automatic logic [2:0] pick_cmd();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 35) return CMD_MAIN;
    else if (w < 50) return CMD_RX;
    else if (w < 60) return CMD_REQUEST;
    else if (w < 67) return CMD_RELEASE;
    else if (w < 87) return CMD_TIMEOUT;
    else if (w < 91) return CMD_SLEEP;
    else if (w < 94) return CMD_INIT;
    else return CMD_UNUSED;
  endfunction

  // activity while the network is up: mostly main steps, some traffic
  function automatic void queue_traffic(int unsigned n);
    int unsigned w;
    repeat (n) begin
      w = $urandom_range(0, 19);
      if (w < 11) queue_any(CMD_MAIN);
      else if (w < 15) queue_any(CMD_RX);
      else if (w < 17) queue_any(CMD_REQUEST);
      else if (w < 18) queue_any(CMD_RELEASE);
      else queue_any(pick_cmd());
    end
  endfunction

  // wake, repeat message, ready sleep or normal, prepare bus sleep, bus sleep
  function automatic void queue_life();
    queue_any($urandom_range(0, 1) ? CMD_RX : CMD_REQUEST);
    queue_any(CMD_MAIN);
    queue_traffic($urandom_range(1, 4));
    queue_event(CMD_TIMEOUT, 1'($urandom_range(0, 1)), TM_REP);
    queue_any(CMD_MAIN);
    queue_traffic($urandom_range(1, 6));
    if ($urandom_range(0, 1)) begin
      queue_any(CMD_RELEASE);
      queue_any(CMD_MAIN);
    end
    queue_event(CMD_TIMEOUT, 1'($urandom_range(0, 1)), TM_NM);
    queue_any(CMD_MAIN);
    queue_traffic($urandom_range(0, 2));
    queue_event(CMD_TIMEOUT, 1'($urandom_range(0, 1)), TM_BUS);
    queue_any(CMD_MAIN);
  endfunction

  function automatic void check_field(string name, logic [3:0] exp_v, logic [3:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endfunction

  task automatic wait_drained();
    while (event_q.size() != 0 || in_valid_i || nm_status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_pdu_byte(input logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_pdu_first_byte_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    pdu_byte_q = v;
  endtask

  // sender: bursts of transactions with random gaps
  always @(posedge clk_i) begin
    logic nxt_valid;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) nm_status_q.push_back(apply_nm_event(cur_ev));
      if (!in_valid_i || in_ready_o) begin
        nxt_valid = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (event_q.size() != 0) begin
          cur_ev = event_q.pop_front();
          nxt_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
        in_valid_i <= nxt_valid;
        cmd_i <= cur_ev.cmd;
        rx_repeat_bit_i <= cur_ev.rx_bit;
        timer_id_i <= cur_ev.tid;
      end
    end
  end

  // receiver: checks each result transaction, stall pattern is chosen by bits 9:8 of a free-running tick
  always @(posedge clk_i) begin
    nm_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (nm_status_q.size() == 0) begin
          $error("result transaction with no prediction pending");
          mismatch_cnt++;
        end else begin
          want = nm_status_q.pop_front();
          check_field("send_nm_pdu", 4'(want.send_nm_pdu), 4'(send_nm_pdu_o));
          check_field("timer_restart_mask", want.restart_mask, timer_restart_mask_o);
          check_field("timer_start_mask", want.start_mask, timer_start_mask_o);
          check_field("timer_stop_mask", want.stop_mask, timer_stop_mask_o);
          check_field("nm_mode", 4'(want.nm_mode), 4'(nm_mode_o));
          check_field("network_substate", 4'(want.substate), 4'(network_substate_o));
          check_field("net_request", 4'(want.net_req), 4'(net_request_o));
        end
      end
      stall_tick <= stall_tick + 16'd1;
      case (stall_tick[9:8])
        2'd0:    out_ready_i <= 1'b1;
        2'd1:    out_ready_i <= ($urandom_range(0, 3) != 0);
        2'd2:    out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= (stall_tick[3:0] >= 4'd3);
      endcase
    end
  end

  initial begin
    logic [7:0] byte_v;
    int unsigned phase_end;
    int unsigned w;
    mode_q = MODE_CODE_SLEEP;
    sub_q = SUB_CODE_NONE;
    wake_q = WK_SLEEP;
    foreach (tm_state[i]) tm_state[i] = TS_STOPPED;
    net_req_q = 1'b0;
    rx_q = 1'b0;
    tx_q = 1'b0;
    rbit_q = 1'b0;
    rep_req_q = 1'b0;
    send_rep_q = 1'b0;
    pdu_byte_q = PDU_FIRST_BYTE_RST;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      repeat (3) @(posedge clk_i);
      case (phase)
        0:       byte_v = 8'h00;
        1:       byte_v = 8'hFF;
        2:       byte_v = 8'($urandom_range(1, 254));
        default: byte_v = PDU_FIRST_BYTE_RST;
      endcase
      write_pdu_byte(byte_v);

      if (phase == 0) begin
        queue_event(CMD_UNUSED, 1'b1, TM_CYC);
        queue_event(CMD_MAIN, 1'b0, TM_REP);
        queue_event(CMD_RX, 1'b0, TM_REP);
        queue_event(CMD_MAIN, 1'b0, TM_REP);
        queue_event(CMD_MAIN, 1'b0, TM_REP);
        queue_event(CMD_TIMEOUT, 1'b0, TM_REP);
        queue_event(CMD_MAIN, 1'b0, TM_REP);
        // repeat request and nm timeout together from ready sleep
        queue_event(CMD_RX, 1'b1, TM_REP);
        queue_event(CMD_TIMEOUT, 1'b0, TM_NM);
        queue_event(CMD_MAIN, 1'b0, TM_REP);
        queue_event(CMD_MAIN, 1'b0, TM_REP);
        queue_event(CMD_TIMEOUT, 1'b0, TM_BUS);
        queue_event(CMD_MAIN, 1'b0, TM_REP);
        queue_event(CMD_REQUEST, 1'b0, TM_REP);
        queue_event(CMD_MAIN, 1'b0, TM_REP);
        queue_event(CMD_TIMEOUT, 1'b0, TM_REP);
        queue_event(CMD_MAIN, 1'b0, TM_REP);
        queue_event(CMD_MAIN, 1'b0, TM_REP);
        queue_event(CMD_RELEASE, 1'b0, TM_REP);
        queue_event(CMD_MAIN, 1'b0, TM_REP);
        queue_event(CMD_TIMEOUT, 1'b1, TM_CYC);
        queue_event(CMD_SLEEP, 1'b0, TM_REP);
        queue_event(CMD_INIT, 1'b1, TM_CYC);
        queue_event(CMD_UNUSED, 1'b0, TM_REP);
      end

      phase_end = events_queued + EVENTS_PER_PHASE;
      while (events_queued < phase_end) begin
        w = $urandom_range(0, 3);
        if (w != 0) begin
          queue_life();
        end else begin
          repeat ($urandom_range(1, 6)) queue_any(pick_cmd());
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: sim.f
src/cnm_pkg.sv
src/cnm_event.sv
src/cnm_out_reg.sv
src/can_network_management_fsm_core.sv
src/cnm_checker.sv
tb/can_network_management_fsm_core_tb.sv
